### rtl/core/lwtc_pkg.sv
// Shared types and constants for the LRU write-through cache.
// Used by lwtc_cell and lru_write_through_cache; no dependencies.
package lwtc_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Payload held by one cell of the recency chain.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  // Per-cell control from the chain controller.
  typedef struct packed {
    logic shift;  // take the neighbor's entry (cell 0 takes the new entry)
  } cell_ctrl_t;

endpackage

### rtl/core/lru_write_through_cache.sv
// An accepted word waits in the request holding register; its outcome is then registered in the result register.
// Throughput: one word per cycle while the result side does not stall.
// Reset: all entries invalid, occupancy zero, capacity register set to 16.
// The tag compare of the cell row is combinational; the recency update is registered in the cells as the word advances.
// Depends on lwtc_pkg and lwtc_cell.
module lru_write_through_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] data_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic signed [31:0] read_value_o,
  output logic               fetch_needed_o,
  output logic               write_through_o,
  output logic signed [31:0] write_key_o,
  output logic signed [31:0] write_value_o,
  output logic               evicted_o,
  output logic signed [31:0] evicted_key_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > lwtc_pkg::CapW) ? CntW : lwtc_pkg::CapW;
  localparam logic [CmpW-1:0] EntriesCmp = CmpW'(ENTRIES);

  // ------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------
  logic [lwtc_pkg::CapW-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lwtc_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // ------------------------------------------------------------------
  // Request holding register: one word waits here until the result
  // register can take its outcome.
  // ------------------------------------------------------------------
  logic                       item_valid_q;
  lwtc_pkg::op_e              op_q;
  logic [lwtc_pkg::KeyW-1:0]  key_q;
  logic [lwtc_pkg::ValW-1:0]  val_q;
  logic                       out_valid_q;
  logic                       advance;
  logic                       accept;

  // Advance the held word whenever the result register is free or draining.
  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= lwtc_pkg::op_e'(operation_i);
      key_q <= key_i;
      val_q <= data_value_i;
    end
  end

  // ------------------------------------------------------------------
  // Cell row. Position 0 is the most recent entry; valid entries always
  // sit in positions 0 .. occupancy-1, so a cell's position is its rank.
  // ------------------------------------------------------------------
  logic [ENTRIES-1:0]             cell_valid;
  lwtc_pkg::entry_t [ENTRIES-1:0] cell_entry;
  logic [ENTRIES-1:0]             cell_match;
  lwtc_pkg::cell_ctrl_t [ENTRIES-1:0] cell_ctrl;
  logic [ENTRIES-1:0]             prev_valid;
  lwtc_pkg::entry_t [ENTRIES-1:0] prev_entry;
  lwtc_pkg::entry_t               head_entry;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_valid[g] = 1'b1;
      assign prev_entry[g] = head_entry;
    end else begin : g_body
      assign prev_valid[g] = cell_valid[g-1];
      assign prev_entry[g] = cell_entry[g-1];
    end

    lwtc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[g]),
      .prev_valid_i (prev_valid[g]),
      .prev_entry_i (prev_entry[g]),
      .search_key_i (key_q),
      .valid_o      (cell_valid[g]),
      .entry_o      (cell_entry[g]),
      .match_o      (cell_match[g])
    );
  end

  // ------------------------------------------------------------------
  // Occupancy and eviction decision
  // ------------------------------------------------------------------
  logic [CntW-1:0] occ_q;
  logic [CmpW-1:0] occ_cmp;
  logic [CmpW-1:0] cap_cmp;
  logic [CmpW-1:0] eff_cap;
  logic [CntW-1:0] occ_last;
  logic            hit;
  logic [IdxW-1:0] hit_pos;
  logic [lwtc_pkg::ValW-1:0] hit_value;
  logic [lwtc_pkg::KeyW-1:0] lru_key;
  logic            is_put;
  logic            insert;
  logic            evict;
  logic            update;
  logic [CntW-1:0] shift_lim;

  assign occ_cmp  = CmpW'(occ_q);
  assign cap_cmp  = CmpW'(cap_q);
  assign occ_last = occ_q - CntW'(1);
  assign is_put   = (op_q == lwtc_pkg::OP_PUT);
  assign hit      = |cell_match;

  // Clamp capacity: zero acts as one, anything above ENTRIES as ENTRIES.
  always_comb begin
    priority if (cap_cmp == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_cmp > EntriesCmp) begin
      eff_cap = EntriesCmp;
    end else begin
      eff_cap = cap_cmp;
    end
  end

  // Encode the matching cell and gather its value and the LRU key.
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    lru_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_pos   = hit_pos | IdxW'(i);
        hit_value = hit_value | cell_entry[i].value;
      end
      if (occ_last == CntW'(i)) begin
        lru_key = lru_key | cell_entry[i].key;
      end
    end
  end

  assign insert = is_put && !hit;
  assign evict  = insert && (occ_cmp >= eff_cap) && (occ_q != '0);
  assign update = hit || insert;

  // Cells 0 .. shift_lim move one place down the chain.
  always_comb begin
    priority if (hit) begin
      shift_lim = CntW'(hit_pos);
    end else if (evict) begin
      shift_lim = occ_last;
    end else begin
      shift_lim = occ_q;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_ctrl
    assign cell_ctrl[g].shift = advance && update && (CntW'(g) <= shift_lim);
  end

  // Head takes the accessed key; a put carries its new value.
  assign head_entry.key   = key_q;
  assign head_entry.value = is_put ? val_q : hit_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (advance && insert && !evict) begin
      occ_q <= occ_q + CntW'(1);
    end
  end

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  logic                      hit_q;
  logic [lwtc_pkg::ValW-1:0] read_value_q;
  logic                      fetch_q;
  logic                      wt_q;
  logic [lwtc_pkg::KeyW-1:0] wkey_q;
  logic [lwtc_pkg::ValW-1:0] wval_q;
  logic                      ev_q;
  logic [lwtc_pkg::KeyW-1:0] evkey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q        <= hit;
      read_value_q <= (!is_put && hit) ? hit_value : '0;
      fetch_q      <= !is_put && !hit;
      wt_q         <= is_put;
      wkey_q       <= is_put ? key_q : '0;
      wval_q       <= is_put ? val_q : '0;
      ev_q         <= evict;
      evkey_q      <= evict ? lru_key : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign read_value_o    = read_value_q;
  assign fetch_needed_o  = fetch_q;
  assign write_through_o = wt_q;
  assign write_key_o     = wkey_q;
  assign write_value_o   = wval_q;
  assign evicted_o       = ev_q;
  assign evicted_key_o   = evkey_q;

endmodule

### rtl/core/lwtc_cell.sv
// One position of the recency-ordered entry chain.
// Depends on lwtc_pkg for entry and control types.
module lwtc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lwtc_pkg::cell_ctrl_t    ctrl_i,
  input  logic                    prev_valid_i,
  input  lwtc_pkg::entry_t        prev_entry_i,
  input  logic [lwtc_pkg::KeyW-1:0] search_key_i,
  output logic                    valid_o,
  output lwtc_pkg::entry_t        entry_o,
  output logic                    match_o
);

  logic             valid_q;
  lwtc_pkg::entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= prev_entry_i;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign match_o = valid_q && (entry_q.key == search_key_i);

endmodule

### test/lru_write_through_cache_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lru_write_through_cache: a queue-fed driver, a stalling monitor
// and an in-bench LRU predictor that checks every result word field by field.
// Depends on lwtc_pkg and the cache RTL.
module lru_write_through_cache_tb;

  localparam int unsigned Lines = 16;
  localparam int unsigned KeyPoolSize = 24;

  // One access as offered on the request channel.
  typedef struct {
    lwtc_pkg::op_e op;
    logic [31:0]   key;
    logic [31:0]   data;
  } access_t;

  // One predicted result word.
  typedef struct {
    logic        hit;
    logic [31:0] read_value;
    logic        fetch_needed;
    logic        write_through;
    logic [31:0] write_key;
    logic [31:0] write_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_result_t;

  // Drive every block input to a known value from time zero.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [4:0]         cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               operation_i = 1'b0;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] data_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic signed [31:0] read_value_o;
  logic               fetch_needed_o;
  logic               write_through_o;
  logic signed [31:0] write_key_o;
  logic signed [31:0] write_value_o;
  logic               evicted_o;
  logic signed [31:0] evicted_key_o;

  lru_write_through_cache #(
    .ENTRIES(Lines)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .data_value_i   (data_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .read_value_o   (read_value_o),
    .fetch_needed_o (fetch_needed_o),
    .write_through_o(write_through_o),
    .write_key_o    (write_key_o),
    .write_value_o  (write_value_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o)
  );

  // Stimulus and expectation stores.
  access_t        access_q[$];
  lookup_result_t lookup_q[$];
  int unsigned    error_count = 0;

  // Idling knobs, set only while the block is idle; the monitor counts hold_off_left down.
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off_left = 0;

  // Predictor state: a shadow of the cache lines and the capacity register.
  logic [31:0] line_key[Lines];
  logic [31:0] line_value[Lines];
  bit          line_valid[Lines];
  int unsigned line_rank[Lines];
  int unsigned lines_used;
  logic [4:0]  capacity_reg;

  logic [31:0] key_pool[KeyPoolSize];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Move a line to rank zero; lines that were more recent age by one.
  function automatic void promote_line(int slot);
    int unsigned r;
    r = line_rank[slot];
    for (int i = 0; i < Lines; i++) begin
      if (line_valid[i] && line_rank[i] < r) line_rank[i]++;
    end
    line_rank[slot] = 0;
  endfunction

  // Predict the result word of one access and advance the shadow state.
  function automatic lookup_result_t apply_access(lwtc_pkg::op_e op, logic [31:0] k,
                                                  logic [31:0] v);
    lookup_result_t r;
    int             slot;
    int unsigned    cap;
    r = '{default: '0};
    slot = -1;
    for (int i = 0; i < Lines; i++) begin
      if (slot < 0 && line_valid[i] && line_key[i] == k) slot = i;
    end
    r.hit = (slot >= 0);

    if (op == lwtc_pkg::OP_GET) begin
      if (slot >= 0) begin
        promote_line(slot);
        r.read_value = line_value[slot];
      end else begin
        r.fetch_needed = 1'b1;
      end
      return r;
    end

    r.write_through = 1'b1;
    r.write_key = k;
    r.write_value = v;

    // Update in place on a present key: no eviction.
    if (slot >= 0) begin
      line_value[slot] = v;
      promote_line(slot);
      return r;
    end

    // Clamp the capacity: zero acts as one, anything past the line count saturates.
    cap = (capacity_reg == 0) ? 1 : capacity_reg;
    if (cap > Lines) cap = Lines;

    // Drop the least recent line when full, or when the capacity was lowered below occupancy.
    if (lines_used >= cap && lines_used > 0) begin
      for (int i = 0; i < Lines; i++) begin
        if (line_valid[i] && line_rank[i] == lines_used - 1) begin
          line_valid[i] = 1'b0;
          lines_used--;
          r.evicted = 1'b1;
          r.evicted_key = line_key[i];
          break;
        end
      end
    end

    // Insert into the first free line as most recent.
    for (int i = 0; i < Lines; i++) begin
      if (!line_valid[i]) begin
        for (int j = 0; j < Lines; j++) begin
          if (line_valid[j]) line_rank[j]++;
        end
        line_valid[i] = 1'b1;
        line_key[i] = k;
        line_value[i] = v;
        line_rank[i] = 0;
        lines_used++;
        break;
      end
    end
    return r;
  endfunction

  // Driver: predict each accepted word, then hold, advance or idle the request channel.
  always @(posedge clk_i or negedge rst_ni) begin
    access_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lookup_q.push_back(apply_access(lwtc_pkg::op_e'(operation_i), key_i, data_value_i));
      end
      // Hold a stalled word as it is; otherwise offer the next one or go idle.
      if (!in_valid_i || !in_stall_o) begin
        if (access_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = access_q.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= nxt.op;
          key_i        <= nxt.key;
          data_value_i <= nxt.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %h, got %h", name, exp, act);
      error_count++;
    end
  endtask

  // Monitor: compare each accepted result word with the oldest prediction, and drive stall.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t exp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          $error("result word with no access outstanding");
          error_count++;
        end else begin
          exp = lookup_q.pop_front();
          check_field("hit", exp.hit, hit_o);
          check_field("read_value", exp.read_value, read_value_o);
          check_field("fetch_needed", exp.fetch_needed, fetch_needed_o);
          check_field("write_through", exp.write_through, write_through_o);
          check_field("write_key", exp.write_key, write_key_o);
          check_field("write_value", exp.write_value, write_value_o);
          check_field("evicted", exp.evicted, evicted_o);
          check_field("evicted_key", exp.evicted_key, evicted_key_o);
        end
      end
      // A long hold-off takes priority over random stalls.
      if (hold_off_left != 0) begin
        out_stall_i <= 1'b1;
        hold_off_left <= hold_off_left - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic push_access(lwtc_pkg::op_e op, logic [31:0] k, logic [31:0] v);
    access_q.push_back('{op: op, key: k, data: v});
  endtask

  // Wait until every queued word is accepted and every result word has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (access_q.size() != 0 || in_valid_i || lookup_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Write the capacity register while idle; mirror it in the predictor.
  task automatic set_capacity(logic [4:0] c);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity_reg = c;
    @(negedge clk_i);
  endtask

  // One random phase: drain, reprogram, set idling, then queue mostly pool-key accesses.
  task automatic run_phase(logic [4:0] cap, int unsigned snd_pct, int unsigned rcv_pct,
                           int unsigned count, int unsigned hold_off);
    logic [31:0] k;
    int unsigned n;
    wait_idle();
    set_capacity(cap);
    sender_idle_pct = snd_pct;
    stall_pct = rcv_pct;
    hold_off_left = hold_off;
    n = 0;
    while (n < count) begin
      // Mostly reuse a small key pool so hits, updates and evictions are common.
      k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(KeyPoolSize - 1)];
      if ($urandom_range(1) == 1) begin
        push_access(lwtc_pkg::OP_PUT, k, $urandom);
        n++;
      end else begin
        push_access(lwtc_pkg::OP_GET, k, $urandom);
        n++;
        // Follow a lookup with the fill a miss would trigger.
        if ($urandom_range(99) < 40) begin
          push_access(lwtc_pkg::OP_PUT, k, $urandom);
          n++;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < Lines; i++) begin
      line_key[i] = '0;
      line_value[i] = '0;
      line_valid[i] = 1'b0;
      line_rank[i] = 0;
    end
    lines_used = 0;
    capacity_reg = lwtc_pkg::CapReset;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h0000_0000;
    for (int i = 4; i < KeyPoolSize; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a lookup of key zero in the cleared store must miss.
    set_capacity(5'd16);
    push_access(lwtc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    push_access(lwtc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_access(lwtc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_access(lwtc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_access(lwtc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_access(lwtc_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    push_access(lwtc_pkg::OP_GET, 32'h0000_3039, 32'h0000_0000);
    // Put to a present key: hit, value updated, no eviction.
    push_access(lwtc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0037);
    push_access(lwtc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_idle();

    // Lower the capacity below occupancy: each insert drops one least recent line.
    set_capacity(5'd2);
    push_access(lwtc_pkg::OP_PUT, 32'h0000_0007, 32'h1111_1111);
    push_access(lwtc_pkg::OP_PUT, 32'h0000_0008, 32'h2222_2222);
    push_access(lwtc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    push_access(lwtc_pkg::OP_GET, 32'h0000_0007, 32'h0000_0000);
    wait_idle();

    // Capacity zero acts as one.
    set_capacity(5'd0);
    push_access(lwtc_pkg::OP_PUT, 32'h0000_0009, 32'h3333_3333);
    push_access(lwtc_pkg::OP_PUT, 32'h0000_000A, 32'h4444_4444);
    push_access(lwtc_pkg::OP_GET, 32'h0000_000A, 32'h0000_0000);
    wait_idle();

    // Capacity past the line count saturates; fill beyond sixteen to force eviction.
    set_capacity(5'd31);
    for (int i = 0; i < 20; i++) begin
      push_access(lwtc_pkg::OP_PUT, 32'h0100_0000 + i, 32'hA5A5_0000 + i);
    end

    // Random phases across capacities and idling modes.
    run_phase(5'd16, 0, 0, 100, 0);
    run_phase(5'd5, 86, 0, 100, 0);
    run_phase(5'd1, 0, 86, 100, 0);
    run_phase(5'd31, 38, 38, 100, 0);
    // Long receiver hold-off with a greedy sender backs the block up.
    run_phase(5'd0, 0, 0, 100, 300);
    run_phase(5'd8, 86, 0, 100, 0);
    run_phase(5'd3, 0, 86, 100, 0);
    run_phase(5'd16, 38, 38, 100, 0);

    wait_idle();
    repeat (5) @(negedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

endmodule
